>>> sv/mctt_pkg.sv
`timescale 1ns / 1ps

package mctt_pkg;

    localparam int TIME_W    = 40;
    localparam int GAP_W     = 20;
    localparam int TICK_W    = 32;
    localparam int TEMPO_W   = 21;
    localparam int HELD_W    = 7;
    localparam int WLEN_W    = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 20;

    // tempo in hundredths of bpm from a mean tick gap in microseconds: 60e6 * 100 / 24
    localparam int SCALE_W = 28;
    localparam logic [SCALE_W-1:0] TEMPO_SCALE = 28'd250000000;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP    = 2'd2;

    localparam logic [WLEN_W-1:0] WINDOW_LEN_RST = 7'd24;
    localparam logic [GAP_W-1:0]  MIN_GAP_RST    = 20'd200;
    localparam logic [GAP_W-1:0]  MAX_GAP_RST    = 20'd500000;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // command kinds handed from the front end to the window engine
    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_FIRST  = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;
    localparam logic [1:0] KIND_ACCEPT = 2'd3;

    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [TIME_W-1:0] time_us;
    } t_in;

    typedef struct packed {
        logic [TEMPO_W-1:0] tempo_centi_bpm;
        logic [TICK_W-1:0]  ticks_seen;
        logic [HELD_W-1:0]  gaps_held;
    } t_out;

    typedef struct packed {
        logic [1:0]        kind;
        logic [GAP_W-1:0]  gap;
        logic [TICK_W-1:0] ticks;
    } t_cmd;

    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_q_wr;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

>>> sv/mctt_front.sv
`timescale 1ns / 1ps

module mctt_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  mctt_pkg::t_in                   i_in_data,
    input  logic [mctt_pkg::GAP_W-1:0]      i_min_gap,
    input  logic [mctt_pkg::GAP_W-1:0]      i_max_gap,
    input  mctt_pkg::t_q_stat               i_q_stat,
    output mctt_pkg::t_q_wr                 o_q_wr
);

    logic [mctt_pkg::TIME_W-1:0] r_last_time, n_last_time;
    logic                        r_have_last, n_have_last;
    logic [mctt_pkg::TICK_W-1:0] r_ticks, n_ticks;

    logic                        w_accept;
    logic [mctt_pkg::TIME_W:0]   w_diff;
    logic                        w_gap_ok;

    assign w_accept   = i_in_valid && !i_q_stat.full;
    assign o_in_stall = i_q_stat.full;

    // negative gap shows as the borrow bit
    assign w_diff = {1'b0, i_in_data.time_us} - {1'b0, r_last_time};
    assign w_gap_ok = !w_diff[mctt_pkg::TIME_W]
        && (w_diff[mctt_pkg::TIME_W-1:mctt_pkg::GAP_W] == '0)
        && (w_diff[mctt_pkg::GAP_W-1:0] >= i_min_gap)
        && (w_diff[mctt_pkg::GAP_W-1:0] <= i_max_gap);

    always_comb begin
        n_last_time     = r_last_time;
        n_have_last     = r_have_last;
        n_ticks         = r_ticks;
        o_q_wr.push     = w_accept;
        o_q_wr.cmd.gap  = w_diff[mctt_pkg::GAP_W-1:0];
        o_q_wr.cmd.kind = mctt_pkg::KIND_CLEAR;
        if (i_in_data.req_type == mctt_pkg::REQ_CLEAR) begin
            n_last_time = '0;
            n_have_last = 1'b0;
            n_ticks     = '0;
        end else begin
            n_last_time = i_in_data.time_us;
            n_have_last = 1'b1;
            n_ticks     = r_ticks + 1'b1;
            if (!r_have_last) begin
                o_q_wr.cmd.kind = mctt_pkg::KIND_FIRST;
            end else if (w_gap_ok) begin
                o_q_wr.cmd.kind = mctt_pkg::KIND_ACCEPT;
            end else begin
                o_q_wr.cmd.kind = mctt_pkg::KIND_REJECT;
            end
        end
        o_q_wr.cmd.ticks = n_ticks;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time <= '0;
            r_have_last <= 1'b0;
            r_ticks     <= '0;
        end else if (w_accept) begin
            r_last_time <= n_last_time;
            r_have_last <= n_have_last;
            r_ticks     <= n_ticks;
        end
    end

endmodule

>>> sv/mctt_queue.sv
`timescale 1ns / 1ps

module mctt_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mctt_pkg::t_q_wr    i_q_wr,
    input  logic               i_pop,
    output mctt_pkg::t_cmd     o_head,
    output mctt_pkg::t_q_stat  o_q_stat
);

    mctt_pkg::t_cmd                r_slot [mctt_pkg::QUEUE_DEPTH];
    logic [mctt_pkg::QPTR_W-1:0]   r_wp, r_rp;
    logic [mctt_pkg::QCNT_W-1:0]   r_cnt;
    logic                          w_push, w_pop;

    assign o_q_stat.full  = (r_cnt == mctt_pkg::QCNT_W'(mctt_pkg::QUEUE_DEPTH));
    assign o_q_stat.empty = (r_cnt == '0);
    assign w_push = i_q_wr.push && !o_q_stat.full;
    assign w_pop  = i_pop && !o_q_stat.empty;
    assign o_head = r_slot[r_rp];

    function automatic logic [mctt_pkg::QPTR_W-1:0] f_inc(
        input logic [mctt_pkg::QPTR_W-1:0] p
    );
        f_inc = (p == mctt_pkg::QPTR_W'(mctt_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wp] <= i_q_wr.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= f_inc(r_wp);
            end
            if (w_pop) begin
                r_rp <= f_inc(r_rp);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> sv/mctt_div.sv
`timescale 1ns / 1ps

module mctt_div #(
    parameter int NUM_W = 35,
    parameter int DEN_W = 27
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [NUM_W-1:0]             i_num,
    input  logic [DEN_W-1:0]             i_den,
    output logic                         o_done,
    output logic [mctt_pkg::TEMPO_W-1:0] o_quo
);

    localparam int CW = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [NUM_W-1:0] r_nsh;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;

    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;

    // restoring division, one quotient bit per cycle
    assign w_trial = {r_rem, r_nsh[NUM_W-1]};
    assign w_diff  = w_trial - {1'b0, i_den};
    assign w_ge    = (w_trial >= {1'b0, i_den});

    assign o_done = r_done;
    assign o_quo  = (r_quo[NUM_W-1:mctt_pkg::TEMPO_W] != '0) ? '1
                                                              : r_quo[mctt_pkg::TEMPO_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_nsh <= i_num;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_nsh <= {r_nsh[NUM_W-2:0], 1'b0};
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

>>> sv/mctt_back.sv
`timescale 1ns / 1ps

module mctt_back #(
    parameter int WINDOW_MAX = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [mctt_pkg::WLEN_W-1:0]   i_window_len,
    input  mctt_pkg::t_cmd                i_head,
    input  mctt_pkg::t_q_stat             i_q_stat,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output mctt_pkg::t_out                o_out_data,
    output logic [$clog2(WINDOW_MAX+1)-1:0] o_win_count
);

    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int SUM_W = mctt_pkg::GAP_W + CNT_W;
    localparam int NUM_W = mctt_pkg::SCALE_W + CNT_W;
    localparam int EW    = (CNT_W > mctt_pkg::WLEN_W) ? CNT_W : mctt_pkg::WLEN_W;
    localparam int SW    = CNT_W + 1;

    localparam logic [mctt_pkg::SCALE_W-1:0] TEMPO_MUL = mctt_pkg::TEMPO_SCALE;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_DROP  = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_DIVGO = 3'd4;
    localparam logic [2:0] S_DIVW  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]                  r_state, n_state;
    logic [CNT_W-1:0]            r_count, n_count;
    logic [PTR_W-1:0]            r_ptr, n_ptr;
    logic [SUM_W-1:0]            r_sum, n_sum;
    logic [mctt_pkg::GAP_W-1:0]  r_gap, n_gap;
    logic [mctt_pkg::TICK_W-1:0] r_ticks, n_ticks;
    logic [mctt_pkg::TEMPO_W-1:0] r_tempo, n_tempo;
    logic [NUM_W-1:0]            r_num, n_num;
    logic                        r_ov, n_ov;
    mctt_pkg::t_out              r_out, n_out;

    logic [mctt_pkg::GAP_W-1:0]  r_mem [WINDOW_MAX];
    logic [mctt_pkg::GAP_W-1:0]  r_rd_data;

    logic [EW-1:0]               w_win, w_eff;
    logic                        w_drop_need;
    logic [SW-1:0]               w_slot_sum, w_slot;
    logic [PTR_W-1:0]            w_slot_idx, w_ptr_inc;
    logic                        w_rd_en, w_wr_en;
    logic                        w_out_free;
    logic                        w_div_done;
    logic [mctt_pkg::TEMPO_W-1:0] w_div_quo;

    // effective window length, limited by the store depth
    assign w_win = EW'(i_window_len);
    assign w_eff = (w_win > EW'(WINDOW_MAX)) ? EW'(WINDOW_MAX) : w_win;
    assign w_drop_need = (r_count != '0) && (EW'(r_count) >= w_eff);

    assign w_slot_sum = SW'(r_ptr) + SW'(r_count);
    assign w_slot     = (w_slot_sum >= SW'(WINDOW_MAX)) ? w_slot_sum - SW'(WINDOW_MAX)
                                                        : w_slot_sum;
    assign w_slot_idx = w_slot[PTR_W-1:0];
    assign w_ptr_inc  = (r_ptr == PTR_W'(WINDOW_MAX - 1)) ? '0 : r_ptr + 1'b1;

    assign w_rd_en = (r_state == S_CHECK) && w_drop_need;
    assign w_wr_en = (r_state == S_CHECK) && !w_drop_need && (w_eff != '0);

    assign w_out_free = !r_ov || !i_out_stall;
    assign o_pop       = (r_state == S_IDLE) && !i_q_stat.empty;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;
    assign o_win_count = r_count;

    mctt_div #(
        .NUM_W (NUM_W),
        .DEN_W (SUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DIVGO),
        .i_num   (r_num),
        .i_den   (r_sum),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_ptr   = r_ptr;
        n_sum   = r_sum;
        n_gap   = r_gap;
        n_ticks = r_ticks;
        n_tempo = r_tempo;
        n_num   = r_num;
        n_ov    = r_ov && i_out_stall;
        n_out   = r_out;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_stat.empty) begin
                    n_gap   = i_head.gap;
                    n_ticks = i_head.ticks;
                    n_tempo = '0;
                    n_state = S_OUT;
                    unique case (i_head.kind) inside
                        mctt_pkg::KIND_CLEAR, mctt_pkg::KIND_REJECT: begin
                            n_count = '0;
                            n_ptr   = '0;
                            n_sum   = '0;
                        end
                        mctt_pkg::KIND_FIRST: begin
                        end
                        mctt_pkg::KIND_ACCEPT: begin
                            n_state = S_CHECK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CHECK: begin
                if (w_drop_need) begin
                    n_state = S_DROP;
                end else if (w_eff == '0) begin
                    n_tempo = '0;
                    n_state = S_OUT;
                end else begin
                    n_sum   = r_sum + SUM_W'(r_gap);
                    n_count = r_count + 1'b1;
                    n_state = S_MUL;
                end
            end
            S_DROP: begin
                n_sum   = r_sum - SUM_W'(r_rd_data);
                n_ptr   = w_ptr_inc;
                n_count = r_count - 1'b1;
                n_state = S_CHECK;
            end
            S_MUL: begin
                if (r_sum == '0) begin
                    n_tempo = '0;
                    n_state = S_OUT;
                end else begin
                    n_num   = NUM_W'(TEMPO_MUL) * NUM_W'(r_count);
                    n_state = S_DIVGO;
                end
            end
            S_DIVGO: begin
                n_state = S_DIVW;
            end
            S_DIVW: begin
                if (w_div_done) begin
                    n_tempo = w_div_quo;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_ov                  = 1'b1;
                    n_out.tempo_centi_bpm = r_tempo;
                    n_out.ticks_seen      = r_ticks;
                    n_out.gaps_held       = mctt_pkg::HELD_W'(r_count);
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_slot_idx] <= r_gap;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[r_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_gap   <= n_gap;
        r_ticks <= n_ticks;
        r_tempo <= n_tempo;
        r_num   <= n_num;
        r_out   <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ptr   <= '0;
            r_sum   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ptr   <= n_ptr;
            r_sum   <= n_sum;
            r_ov    <= n_ov;
        end
    end

endmodule

>>> sv/midi_clock_tempo_tracker_core.sv
`timescale 1ns / 1ps
// channel   direction  handshake              payload
// in        in         i_in_valid / o_in_stall  i_in_data   (t_in: req_type, time_us)
// out       out        o_out_valid / i_out_stall o_out_data (t_out: tempo, ticks, gaps)
// cfg       in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// back end: a clear, a first tick or a rejected gap goes straight to the output
// state; an accepted gap first drops the oldest window entries while the window
// is full, then adds the gap and runs the divider, one quotient bit per cycle;
// a zero window or a zero sum skips the divide
// reset is synchronous, active low; the gap store needs no clearing pass
// a two-entry command queue keeps input taken while the divider or output is busy

module midi_clock_tempo_tracker_core #(
    parameter int WINDOW_MAX = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  mctt_pkg::t_in                     i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output mctt_pkg::t_out                    o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mctt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mctt_pkg::CFG_DAT_W-1:0]    i_cfg_data
);

    localparam int CNT_W = $clog2(WINDOW_MAX + 1);

    // configuration registers; the user must write them only while the tracker is quiet, the block does no such check
    logic [mctt_pkg::WLEN_W-1:0] r_window_len;
    logic [mctt_pkg::GAP_W-1:0]  r_min_gap;
    logic [mctt_pkg::GAP_W-1:0]  r_max_gap;

    mctt_pkg::t_q_wr   w_q_wr;
    mctt_pkg::t_q_stat w_q_stat;
    mctt_pkg::t_cmd    w_head;
    logic              w_pop;
    logic [CNT_W-1:0]  w_win_count;

    // the port never holds off a register write
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= mctt_pkg::WINDOW_LEN_RST;
            r_min_gap    <= mctt_pkg::MIN_GAP_RST;
            r_max_gap    <= mctt_pkg::MAX_GAP_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                mctt_pkg::CFG_WINDOW_LEN: r_window_len <= i_cfg_data[mctt_pkg::WLEN_W-1:0];
                mctt_pkg::CFG_MIN_GAP:    r_min_gap    <= i_cfg_data;
                mctt_pkg::CFG_MAX_GAP:    r_max_gap    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // front end: timestamp bookkeeping and gap classification
    mctt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_min_gap  (r_min_gap),
        .i_max_gap  (r_max_gap),
        .i_q_stat   (w_q_stat),
        .o_q_wr     (w_q_wr)
    );

    // classified transactions wait here for the window engine
    mctt_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_wr   (w_q_wr),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_q_stat (w_q_stat)
    );

    // back end: sliding window, running sum, tempo divide, output register
    mctt_back #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_window_len (r_window_len),
        .i_head       (w_head),
        .i_q_stat     (w_q_stat),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data),
        .o_win_count  (w_win_count)
    );

    // the front end never pushes into a full queue
    a_q_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_wr.push |-> !w_q_stat.full)
        else $error("command queue overflow");

    // a push into an empty queue leaves something for the back end
    a_q_push_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_wr.push && w_q_stat.empty) |=> !w_q_stat.empty)
        else $error("queued transaction lost");

    // the window never holds more gaps than the store has entries
    a_win_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_win_count <= CNT_W'(WINDOW_MAX))
        else $error("window count beyond store depth");

    // an empty window always reports zero tempo
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.gaps_held == '0) && (WINDOW_MAX < 128))
            |-> (o_out_data.tempo_centi_bpm == '0))
        else $error("tempo reported with empty window");

endmodule
